@@ hdl/pib_pkg.sv @@
package pib_pkg;

   localparam int unsigned MAX_WIN = 64;
   localparam int unsigned SLOT_BITS = 6;

   localparam logic [2:0] CSR_SHORT_WINDOW = 3'd0;
   localparam logic [2:0] CSR_LONG_WINDOW = 3'd1;
   localparam logic [2:0] CSR_RSI_WINDOW = 3'd2;
   localparam logic [2:0] CSR_FAST_PERIOD = 3'd3;
   localparam logic [2:0] CSR_SLOW_PERIOD = 3'd4;
   localparam logic [2:0] CSR_SIGNAL_PERIOD = 3'd5;

   localparam logic [14:0] RSI_FULL = 15'd25600;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [17:0] ALPHA_NUM = 18'd131072;
   localparam logic [5:0] DIV_STEPS = 6'd56;
   localparam logic [5:0] MUL_STEPS = 6'd17;

   typedef struct packed {
      logic [31:0] price;
      logic        series_start;
   } req_type;

   typedef struct packed {
      logic [31:0]        avg_short;
      logic               avg_short_valid;
      logic [31:0]        avg_long;
      logic               avg_long_valid;
      logic [14:0]        rsi_value;
      logic               rsi_valid;
      logic signed [31:0] macd_value;
      logic               macd_valid;
      logic signed [31:0] signal_value;
      logic               signal_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_PREV, S_SCAN, S_SMA_S, S_W_SHORT, S_W_LONG, S_W_RSIM, S_W_RSID,
      S_EMA, S_W_SEED, S_W_ALPHA, S_W_MX, S_W_MA, S_MACD, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_FAST, SEL_SLOW, SEL_SIGNAL
   } ema_sel_type;

   typedef enum logic {
      OP_DIV, OP_MUL
   } arith_op_type;

   typedef struct packed {
      logic               go;
      arith_op_type       op;
      logic               keep_acc;
      logic signed [59:0] opa;
      logic [39:0]        opb;
   } arith_cmd_type;

   typedef struct packed {
      logic               done;
      logic [55:0]        quo;
      logic signed [59:0] acc;
   } arith_rsp_type;

   function automatic logic [6:0] eff_len(input logic [6:0] v);
      logic [6:0] r;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (v > 7'(MAX_WIN)) begin
         r = 7'(MAX_WIN);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ hdl/pib_ram.sv @@
module pib_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/pib_arith.sv @@
module pib_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  pib_pkg::arith_cmd_type cmd,
   output pib_pkg::arith_rsp_type rsp
);
   import pib_pkg::*;

   logic               busy_ff, busy_in, done_ff, done_in;
   arith_op_type       op_ff, op_in;
   logic [5:0]         cnt_ff, cnt_in, last;
   logic [39:0]        rem_ff, rem_in, den_ff, den_in;
   logic [55:0]        quo_ff, quo_in;
   logic signed [59:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [16:0]        bits_ff, bits_in;
   logic [40:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      bits_in = bits_ff;
      trial = {rem_ff, quo_ff[55]};
      last = (op_ff == OP_DIV) ? DIV_STEPS - 6'd1 : MUL_STEPS - 6'd1;
      if (cmd.go) begin
         op_in = cmd.op;
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = cmd.opa[55:0];
         den_in = cmd.opb;
         mcand_in = cmd.opa;
         bits_in = cmd.opb[16:0];
         if (!cmd.keep_acc) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_DIV: begin
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = 40'(trial - {1'b0, den_ff});
                  quo_in = {quo_ff[54:0], 1'b1};
               end else begin
                  rem_in = trial[39:0];
                  quo_in = {quo_ff[54:0], 1'b0};
               end
            end
            OP_MUL: begin
               if (bits_ff[0]) begin
                  acc_in = acc_ff + mcand_ff;
               end
               mcand_in = mcand_ff <<< 1;
               bits_in = bits_ff >> 1;
            end
         endcase
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= OP_DIV;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff <= op_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      bits_ff <= bits_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo = quo_ff;
   assign rsp.acc = acc_ff;

   a_no_go_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.go |-> !busy_ff) else $error("arith unit started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("arith unit done without work");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= last)) else $error("arith unit step count overran");

endmodule

@@ hdl/price_indicator_bank_top.sv @@
// Price indicator bank: moving averages, RSI and MACD over a stream of prices.
// Requests arrive on req_valid/req_stall/req_data; each carries one unsigned
// Q16.16 closing price and a series-start flag that clears all history first.
// Every request yields exactly one result on rsp_valid/rsp_stall/rsp_data.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while idle; the block itself does not enforce it.
// One request is worked on at a time: the rings are written and all 64
// entries are scanned, one entry per cycle from a registered memory port,
// then quotients and products are formed in the one shared divide/multiply
// unit; the two averages take two quotients, the RSI a product and a
// quotient unless it is set to zero or full directly, and each running
// average a quotient to seed it and a quotient plus two products once
// seeded. A new request is taken in the cycle after the result is
// registered at the earliest.
// The result sits in an output register, so a stalled receiver does not stop
// the next request from being taken; only the following result waits for it.
// Reset restores the default windows and clears the history counters; the
// ring memories are not cleared and are only read where written since then.
module price_indicator_bank_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pib_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pib_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [6:0]       csr_wdata
);
   import pib_pkg::*;

   state_type          state_ff, state_in;
   ema_sel_type        sel_ff, sel_in;
   logic [6:0]         cfg_short_ff, cfg_long_ff, cfg_fast_ff, cfg_slow_ff, cfg_signal_ff;
   logic [5:0]         cfg_rsi_ff;
   logic [31:0]        price_ff, price_in;
   logic [6:0]         count_ff, count_in, mcount_ff, mcount_in;
   logic [5:0]         slot_ff, slot_in;
   logic [37:0]        short_ff, short_in, long_ff, long_in, gain_ff, gain_in;
   logic [37:0]        loss_ff, loss_in, fast_ff, fast_in, slow_ff, slow_in;
   logic signed [39:0] sig_ff, sig_in;
   logic [6:0]         scan_k_ff, scan_k_in;
   logic [5:0]         dk_ff, dk_in;
   logic               dvld_ff, dvld_in;
   logic [31:0]        sma_s_ff, sma_s_in, sma_l_ff, sma_l_in;
   logic [14:0]        rsi_ff, rsi_in;
   logic signed [31:0] macd_ff, macd_in;
   logic [16:0]        alpha_ff, alpha_in;
   logic               neg_ff, neg_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               ram_we;
   logic [5:0]         ram_waddr, ram_raddr;
   logic [31:0]        price_rdata;
   logic [32:0]        diff_wdata, diff_rdata, dneg;
   arith_cmd_type      cmd;
   arith_rsp_type      arsp;

   logic [6:0]         ws_e, wl_e, wr_e, pf_e, ps_e, pg_e, e_p, e_n, dk7;
   logic [7:0]         p1;
   logic signed [59:0] e_x, e_avg, e_sum, store_val, q60, seed_v, mag;
   logic               e_sig, store_en, rv, loss_zero, mv, sv, lv, gv, accept;
   logic signed [39:0] macd_diff;

   function automatic logic signed [59:0] wrap_avg(input logic signed [59:0] v,
                                                   input logic is_sig);
      logic signed [59:0] r;
      if (is_sig) begin
         r = 60'(signed'(v[39:0]));
      end else begin
         r = 60'(v[37:0]);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   pib_ram #(.WIDTH(32), .DEPTH(MAX_WIN)) u_price_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(price_ff),
      .rd_addr(ram_raddr), .rd_data(price_rdata)
   );

   pib_ram #(.WIDTH(33), .DEPTH(MAX_WIN)) u_diff_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(diff_wdata),
      .rd_addr(ram_raddr), .rd_data(diff_rdata)
   );

   pib_arith u_arith (.clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp));

   assign ws_e = eff_len(cfg_short_ff);
   assign wl_e = eff_len(cfg_long_ff);
   assign wr_e = eff_len({1'b0, cfg_rsi_ff});
   assign pf_e = eff_len(cfg_fast_ff);
   assign ps_e = eff_len(cfg_slow_ff);
   assign pg_e = eff_len(cfg_signal_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign rv = count_ff > wr_e;
   assign sv = count_ff >= ws_e;
   assign lv = count_ff >= wl_e;
   assign mv = (count_ff >= pf_e) && (count_ff >= ps_e);
   assign gv = mv && (mcount_ff >= pg_e);
   assign loss_zero = (loss_ff == 38'd0);
   assign dk7 = {1'b0, dk_ff};
   assign dneg = 33'd0 - diff_rdata;

   always_comb begin
      unique case (sel_ff)
         SEL_FAST: begin
            e_p = pf_e;
            e_n = count_ff;
            e_x = 60'(price_ff);
            e_avg = 60'(fast_ff);
            e_sig = 1'b0;
         end
         SEL_SLOW: begin
            e_p = ps_e;
            e_n = count_ff;
            e_x = 60'(price_ff);
            e_avg = 60'(slow_ff);
            e_sig = 1'b0;
         end
         default: begin
            e_p = pg_e;
            e_n = mcount_ff;
            e_x = 60'(macd_ff);
            e_avg = 60'(sig_ff);
            e_sig = 1'b1;
         end
      endcase
      e_sum = e_x + e_avg;
      p1 = {1'b0, e_p} + 8'd1;
      mag = wrap_avg(e_sum, e_sig);
      if (mag < 0) begin
         mag = -mag;
      end
      q60 = 60'(arsp.quo);
      seed_v = neg_ff ? -q60 : q60;
      macd_diff = $signed({2'b00, fast_ff}) - $signed({2'b00, slow_ff});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = S_PREV;
         S_PREV:    state_in = S_SCAN;
         S_SCAN:    if (dvld_ff && dk_ff == 6'(MAX_WIN - 1)) state_in = S_SMA_S;
         S_SMA_S:   state_in = S_W_SHORT;
         S_W_SHORT: if (arsp.done) state_in = S_W_LONG;
         S_W_LONG: begin
            if (arsp.done) begin
               state_in = (!rv || loss_zero) ? S_EMA : S_W_RSIM;
            end
         end
         S_W_RSIM:  if (arsp.done) state_in = S_W_RSID;
         S_W_RSID:  if (arsp.done) state_in = S_EMA;
         S_EMA: begin
            if (e_n < e_p) begin
               state_in = (sel_ff == SEL_FAST) ? S_EMA :
                          (sel_ff == SEL_SLOW) ? (mv ? S_MACD : S_OUT) : S_OUT;
            end else if (e_n == e_p) begin
               state_in = S_W_SEED;
            end else begin
               state_in = S_W_ALPHA;
            end
         end
         S_W_ALPHA: if (arsp.done) state_in = S_W_MX;
         S_W_MX:    if (arsp.done) state_in = S_W_MA;
         S_W_SEED, S_W_MA: begin
            if (arsp.done) begin
               state_in = (sel_ff == SEL_FAST) ? S_EMA :
                          (sel_ff == SEL_SLOW) ? (mv ? S_MACD : S_OUT) : S_OUT;
            end
         end
         S_MACD:    state_in = S_EMA;
         S_OUT:     if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      sel_in = sel_ff;
      price_in = price_ff;
      count_in = count_ff;
      mcount_in = mcount_ff;
      slot_in = slot_ff;
      short_in = short_ff;
      long_in = long_ff;
      gain_in = gain_ff;
      loss_in = loss_ff;
      fast_in = fast_ff;
      slow_in = slow_ff;
      sig_in = sig_ff;
      scan_k_in = scan_k_ff;
      dk_in = dk_ff;
      dvld_in = 1'b0;
      sma_s_in = sma_s_ff;
      sma_l_in = sma_l_ff;
      rsi_in = rsi_ff;
      macd_in = macd_ff;
      alpha_in = alpha_ff;
      neg_in = neg_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we = 1'b0;
      ram_waddr = slot_ff;
      ram_raddr = slot_ff - 6'd1;
      diff_wdata = '0;
      cmd = '0;
      store_en = 1'b0;
      store_val = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               price_in = req_data.price;
               if (req_data.series_start) begin
                  count_in = '0;
                  mcount_in = '0;
                  slot_in = '0;
                  fast_in = '0;
                  slow_in = '0;
                  sig_in = '0;
               end
            end
         end
         S_PREV: begin
            if (count_ff != 7'd0) begin
               diff_wdata = {1'b0, price_ff} - {1'b0, price_rdata};
            end
            ram_we = 1'b1;
            slot_in = slot_ff + 6'd1;
            if (count_ff != 7'd127) begin
               count_in = count_ff + 7'd1;
            end
            short_in = '0;
            long_in = '0;
            gain_in = '0;
            loss_in = '0;
            scan_k_in = '0;
         end
         S_SCAN: begin
            ram_raddr = slot_ff - 6'd1 - scan_k_ff[5:0];
            if (scan_k_ff < 7'(MAX_WIN)) begin
               dk_in = scan_k_ff[5:0];
               dvld_in = 1'b1;
               scan_k_in = scan_k_ff + 7'd1;
            end
            if (dvld_ff) begin
               if (dk7 < ws_e && dk7 < count_ff) begin
                  short_in = short_ff + 38'(price_rdata);
               end
               if (dk7 < wl_e && dk7 < count_ff) begin
                  long_in = long_ff + 38'(price_rdata);
               end
               if (dk7 < wr_e && (dk7 + 7'd1) < count_ff) begin
                  if ($signed(diff_rdata) > 33'sd0) begin
                     gain_in = gain_ff + 38'(diff_rdata[31:0]);
                  end else begin
                     loss_in = loss_ff + 38'(dneg[31:0]);
                  end
               end
            end
         end
         S_SMA_S: begin
            sel_in = SEL_FAST;
            cmd.go = 1'b1;
            cmd.op = OP_DIV;
            cmd.opa = 60'(short_ff);
            cmd.opb = 40'(ws_e);
         end
         S_W_SHORT: begin
            if (arsp.done) begin
               sma_s_in = arsp.quo[31:0];
               cmd.go = 1'b1;
               cmd.op = OP_DIV;
               cmd.opa = 60'(long_ff);
               cmd.opb = 40'(wl_e);
            end
         end
         S_W_LONG: begin
            if (arsp.done) begin
               sma_l_in = arsp.quo[31:0];
               if (!rv) begin
                  rsi_in = '0;
               end else if (loss_zero) begin
                  rsi_in = RSI_FULL;
               end else begin
                  cmd.go = 1'b1;
                  cmd.op = OP_MUL;
                  cmd.opa = 60'(gain_ff);
                  cmd.opb = 40'(RSI_FULL);
               end
            end
         end
         S_W_RSIM: begin
            if (arsp.done) begin
               cmd.go = 1'b1;
               cmd.op = OP_DIV;
               cmd.opa = arsp.acc;
               cmd.opb = 40'({1'b0, gain_ff} + {1'b0, loss_ff});
            end
         end
         S_W_RSID: begin
            if (arsp.done) begin
               rsi_in = arsp.quo[14:0];
            end
         end
         S_EMA: begin
            if (e_n < e_p) begin
               store_en = 1'b1;
               store_val = wrap_avg(e_sum, e_sig);
            end else if (e_n == e_p) begin
               neg_in = wrap_avg(e_sum, e_sig) < 0;
               cmd.go = 1'b1;
               cmd.op = OP_DIV;
               cmd.opa = mag;
               cmd.opb = 40'(e_p);
            end else begin
               cmd.go = 1'b1;
               cmd.op = OP_DIV;
               cmd.opa = 60'(ALPHA_NUM + 18'(p1 >> 1));
               cmd.opb = 40'(p1);
            end
         end
         S_W_SEED: begin
            if (arsp.done) begin
               store_en = 1'b1;
               store_val = wrap_avg(seed_v, e_sig);
            end
         end
         S_W_ALPHA: begin
            if (arsp.done) begin
               alpha_in = arsp.quo[16:0];
               cmd.go = 1'b1;
               cmd.op = OP_MUL;
               cmd.opa = e_x;
               cmd.opb = 40'(arsp.quo[16:0]);
            end
         end
         S_W_MX: begin
            if (arsp.done) begin
               cmd.go = 1'b1;
               cmd.op = OP_MUL;
               cmd.keep_acc = 1'b1;
               cmd.opa = e_avg;
               cmd.opb = 40'(ONE_Q16 - alpha_ff);
            end
         end
         S_W_MA: begin
            if (arsp.done) begin
               store_en = 1'b1;
               store_val = wrap_avg(arsp.acc >>> 16, e_sig);
            end
         end
         S_MACD: begin
            macd_in = sat32(macd_diff);
            if (mcount_ff != 7'd127) begin
               mcount_in = mcount_ff + 7'd1;
            end
            sel_in = SEL_SIGNAL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.avg_short = sv ? sma_s_ff : '0;
               rsp_data_in.avg_short_valid = sv;
               rsp_data_in.avg_long = lv ? sma_l_ff : '0;
               rsp_data_in.avg_long_valid = lv;
               rsp_data_in.rsi_value = rv ? rsi_ff : '0;
               rsp_data_in.rsi_valid = rv;
               rsp_data_in.macd_value = mv ? macd_ff : '0;
               rsp_data_in.macd_valid = mv;
               rsp_data_in.signal_value = gv ? sat32(sig_ff) : '0;
               rsp_data_in.signal_valid = gv;
            end
         end
         default: begin
         end
      endcase
      if (store_en) begin
         unique case (sel_ff)
            SEL_FAST: begin
               fast_in = store_val[37:0];
               sel_in = SEL_SLOW;
            end
            SEL_SLOW: slow_in = store_val[37:0];
            default:  sig_in = store_val[39:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= SEL_FAST;
         count_ff <= '0;
         mcount_ff <= '0;
         slot_ff <= '0;
         fast_ff <= '0;
         slow_ff <= '0;
         sig_ff <= '0;
         dvld_ff <= 1'b0;
         scan_k_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_short_ff <= 7'd20;
         cfg_long_ff <= 7'd50;
         cfg_rsi_ff <= 6'd14;
         cfg_fast_ff <= 7'd12;
         cfg_slow_ff <= 7'd26;
         cfg_signal_ff <= 7'd9;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         count_ff <= count_in;
         mcount_ff <= mcount_in;
         slot_ff <= slot_in;
         fast_ff <= fast_in;
         slow_ff <= slow_in;
         sig_ff <= sig_in;
         dvld_ff <= dvld_in;
         scan_k_ff <= scan_k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SHORT_WINDOW:  cfg_short_ff <= csr_wdata;
               CSR_LONG_WINDOW:   cfg_long_ff <= csr_wdata;
               CSR_RSI_WINDOW:    cfg_rsi_ff <= csr_wdata[5:0];
               CSR_FAST_PERIOD:   cfg_fast_ff <= csr_wdata;
               CSR_SLOW_PERIOD:   cfg_slow_ff <= csr_wdata;
               CSR_SIGNAL_PERIOD: cfg_signal_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      short_ff <= short_in;
      long_ff <= long_in;
      gain_ff <= gain_in;
      loss_ff <= loss_in;
      dk_ff <= dk_in;
      sma_s_ff <= sma_s_in;
      sma_l_ff <= sma_l_in;
      rsi_ff <= rsi_in;
      macd_ff <= macd_in;
      alpha_ff <= alpha_in;
      neg_ff <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PREV) |=> (slot_ff == $past(slot_ff) + 6'd1))
      else $error("ring slot did not advance after a write");
   a_scan_has_history: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != 7'd0))
      else $error("ring scanned with no price recorded");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && rsp_stall)
      |=> (state_ff == S_OUT && $stable(rsp_data_ff)))
      else $error("pending result overwritten");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      arsp.done |-> (state_ff == S_W_SHORT || state_ff == S_W_LONG ||
                     state_ff == S_W_RSIM || state_ff == S_W_RSID ||
                     state_ff == S_W_SEED || state_ff == S_W_ALPHA ||
                     state_ff == S_W_MX || state_ff == S_W_MA))
      else $error("arith result arrived outside a wait state");

endmodule
